// ===== hw/rtl/tdr_pkg.sv =====
// ----------------------------------------------------------------------------
// tdr_pkg
// shared types and codes for the transmit descriptor ring controller
// ----------------------------------------------------------------------------
package tdr_pkg;

    localparam int LEN_W       = 12;
    localparam int SLOT_W      = 6;
    localparam int FREE_W      = 7;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int WALK_W      = 6;

    localparam logic [LEN_W-1:0]  MIN_LEN_RESET = 12'd60;
    // one walk releases at most this many slots
    localparam logic [WALK_W-1:0] WALK_MAX      = 6'd63;

    localparam logic [KIND_W-1:0] KIND_POST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WALK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_POSTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_END    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK_RD,
        S_WALK_CHK,
        S_OUT
    } t_state;

endpackage

// ===== hw/rtl/tdr_own_mem.sv =====
// ----------------------------------------------------------------------------
// tdr_own_mem
// ownership flag memory, one bit per slot, cleared by a sweep after reset
// ----------------------------------------------------------------------------
module tdr_own_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata,
    output logic          o_busy
);

    logic          r_mem [DEPTH];
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic          r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clearing;

endmodule

// ===== hw/rtl/tdr_step_unit.sv =====
// ----------------------------------------------------------------------------
// tdr_step_unit
// shared arithmetic: wrapping index advance, free count step, pad compare
// ----------------------------------------------------------------------------
module tdr_step_unit
    import tdr_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic [AW-1:0]    i_idx,
    input  logic [CW-1:0]    i_cnt,
    input  logic             i_cnt_up,
    input  logic [LEN_W-1:0] i_len,
    input  logic [LEN_W-1:0] i_min_len,
    output logic [AW-1:0]    o_idx_next,
    output logic [CW-1:0]    o_cnt_next,
    output logic [LEN_W-1:0] o_len_pad
);

    // wrap at the ring end, depth need not be a power of two
    assign o_idx_next = (i_idx == AW'(DEPTH - 1)) ? '0 : i_idx + 1'b1;
    assign o_cnt_next = i_cnt_up ? i_cnt + 1'b1 : i_cnt - 1'b1;
    assign o_len_pad  = (i_len > i_min_len) ? i_len : i_min_len;

endmodule

// ===== hw/rtl/tx_descriptor_ring.sv =====
// ----------------------------------------------------------------------------
// tx_descriptor_ring
// transmit descriptor ring controller: post, nic done and completion walk
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall carry one word (kind, payload
//   length, done slot). the block takes one word at a time and holds
//   o_in_stall high until every result of that word has been delivered.
//   output channel: o_out_valid / i_out_stall carry result words from an
//   output register; a stalled result holds until taken.
//   a post goes through accept, execute and deliver, plus output wait; a
//   nic done is accepted and executed and gives no result. a completion
//   walk goes through execute, then memory read, check and deliver for
//   each released slot, then its end marker; a walk that stops at a slot
//   the nic still owns gives the marker from that slot's check.
//   min_frame_len is written through i_cfg_we / i_cfg_wdata while no word
//   is in flight; the user keeps to that, the block does not enforce it.
//   after reset the ownership memory is swept clear, one slot a cycle; the
//   input stays stalled during the sweep. while the receiver stalls, the
//   block waits with the result held.
// ----------------------------------------------------------------------------
module tx_descriptor_ring
    import tdr_pkg::*;
#(
    parameter int RING_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic [LEN_W-1:0]    i_cfg_wdata,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [LEN_W-1:0]    i_payload_length,
    input  logic [SLOT_W-1:0]   i_done_slot,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [LEN_W-1:0]    o_padded_len,
    output logic                o_end_of_ring,
    output logic [FREE_W-1:0]   o_free_slots,
    output logic                o_last
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);

    // control state
    t_state          r_state, n_state;
    t_state          r_ret, n_ret;
    logic [AW-1:0]   r_prod, n_prod;
    logic [AW-1:0]   r_cons, n_cons;
    logic [CW-1:0]   r_free, n_free;
    logic [WALK_W-1:0] r_walk_n, n_walk_n;
    logic [LEN_W-1:0] r_min_len;
    logic            r_out_valid, n_out_valid;

    // latched input word
    logic [KIND_W-1:0] r_kind;
    logic [LEN_W-1:0]  r_plen;
    logic [SLOT_W-1:0] r_dslot;

    // result register
    logic [STATUS_W-1:0] r_status, n_status;
    logic [AW-1:0]       r_slot, n_slot;
    logic [LEN_W-1:0]    r_flen, n_flen;
    logic                r_end, n_end;
    logic [CW-1:0]       r_free_out, n_free_out;
    logic                r_last, n_last;

    // memory and shared unit hookup
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic            mem_wdata;
    logic            mem_rdata;
    logic            mem_busy;
    logic [AW-1:0]   step_idx;
    logic            step_up;
    logic [AW-1:0]   step_idx_next;
    logic [CW-1:0]   step_cnt_next;
    logic [LEN_W-1:0] step_len_pad;

    logic            in_accept;
    logic            out_accept;
    logic            dslot_ok;
    logic            ring_full;
    logic            can_walk;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_accept = r_out_valid && !i_out_stall;
    assign dslot_ok   = 32'(r_dslot) < RING_DEPTH;
    assign ring_full  = (r_free == '0);
    assign can_walk   = (r_free < CW'(RING_DEPTH)) && (r_walk_n < WALK_MAX);

    // ownership flags, read address follows the consumer index
    tdr_own_mem #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_own_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_cons),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    // one index advance and one count step serve both post and walk
    assign step_idx = (r_state == S_WALK_CHK) ? r_cons : r_prod;
    assign step_up  = (r_state == S_WALK_CHK);

    tdr_step_unit #(
        .DEPTH (RING_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_step (
        .i_idx      (step_idx),
        .i_cnt      (r_free),
        .i_cnt_up   (step_up),
        .i_len      (r_plen),
        .i_min_len  (r_min_len),
        .o_idx_next (step_idx_next),
        .o_cnt_next (step_cnt_next),
        .o_len_pad  (step_len_pad)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_prod      <= '0;
            r_cons      <= '0;
            r_free      <= CW'(RING_DEPTH);
            r_walk_n    <= '0;
            r_min_len   <= MIN_LEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_prod      <= n_prod;
            r_cons      <= n_cons;
            r_free      <= n_free;
            r_walk_n    <= n_walk_n;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_min_len <= i_cfg_wdata;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind  <= i_kind;
            r_plen  <= i_payload_length;
            r_dslot <= i_done_slot;
        end
        r_status   <= n_status;
        r_slot     <= n_slot;
        r_flen     <= n_flen;
        r_end      <= n_end;
        r_free_out <= n_free_out;
        r_last     <= n_last;
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_prod      = r_prod;
        n_cons      = r_cons;
        n_free      = r_free;
        n_walk_n    = r_walk_n;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_slot      = r_slot;
        n_flen      = r_flen;
        n_end       = r_end;
        n_free_out  = r_free_out;
        n_last      = r_last;
        mem_we      = 1'b0;
        mem_waddr   = r_prod;
        mem_wdata   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                unique case (r_kind)
                    KIND_POST: begin
                        n_state     = S_OUT;
                        n_ret       = S_IDLE;
                        n_out_valid = 1'b1;
                        n_slot      = r_prod;
                        n_end       = (r_prod == AW'(RING_DEPTH - 1));
                        n_last      = 1'b1;
                        if (ring_full) begin
                            // rejected, no state change
                            n_status   = ST_FULL;
                            n_flen     = '0;
                            n_free_out = '0;
                        end else begin
                            mem_we     = 1'b1;
                            mem_waddr  = r_prod;
                            mem_wdata  = 1'b1;
                            n_prod     = step_idx_next;
                            n_free     = step_cnt_next;
                            n_status   = ST_POSTED;
                            n_flen     = step_len_pad;
                            n_free_out = step_cnt_next;
                        end
                    end
                    KIND_DONE: begin
                        // slots beyond the ring are ignored
                        mem_we    = dslot_ok;
                        mem_waddr = AW'(r_dslot);
                        mem_wdata = 1'b0;
                        n_state   = S_IDLE;
                    end
                    KIND_WALK: begin
                        n_walk_n = '0;
                        n_state  = S_WALK_RD;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_WALK_RD: begin
                // memory read of the consumer slot is in flight
                if (can_walk) begin
                    n_state = S_WALK_CHK;
                end else begin
                    n_state     = S_OUT;
                    n_ret       = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_END;
                    n_slot      = r_cons;
                    n_end       = (r_cons == AW'(RING_DEPTH - 1));
                    n_flen      = '0;
                    n_free_out  = r_free;
                    n_last      = 1'b1;
                end
            end

            S_WALK_CHK: begin
                n_state     = S_OUT;
                n_out_valid = 1'b1;
                n_slot      = r_cons;
                n_end       = (r_cons == AW'(RING_DEPTH - 1));
                n_flen      = '0;
                if (mem_rdata) begin
                    // still owned by the nic, walk stops here
                    n_ret      = S_IDLE;
                    n_status   = ST_END;
                    n_free_out = r_free;
                    n_last     = 1'b1;
                end else begin
                    n_ret      = S_WALK_RD;
                    n_status   = ST_DONE;
                    n_cons     = step_idx_next;
                    n_free     = step_cnt_next;
                    n_free_out = step_cnt_next;
                    n_walk_n   = r_walk_n + 1'b1;
                    n_last     = 1'b0;
                end
            end

            S_OUT: begin
                if (out_accept) begin
                    n_out_valid = 1'b0;
                    n_state     = r_ret;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall     = (r_state != S_IDLE) || mem_busy;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_slot         = SLOT_W'(r_slot);
    assign o_padded_len   = r_flen;
    assign o_end_of_ring  = r_end;
    assign o_free_slots   = FREE_W'(r_free_out);
    assign o_last         = r_last;

endmodule

// ===== test/tx_descriptor_ring_test.sv =====
// ----------------------------------------------------------------------------
// tx_descriptor_ring_test
// self-checking bench for the transmit descriptor ring controller: posts,
// nic done words and completion walks go in through the valid/stall input
// channel; a scoreboard keeps its own copy of the ring and checks every
// result word in order under random input gaps and output stalls
// ----------------------------------------------------------------------------
module tx_descriptor_ring_test
    import tdr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_SLOTS = 64;
    // kind code the block ignores
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    // cycles allowed after the last result before the block counts as idle
    localparam int IDLE_GUARD = 8;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_WORDS = 25;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [LEN_W-1:0]    padded_len;
        logic                end_of_ring;
        logic [FREE_W-1:0]   free_slots;
        logic                last;
    } t_result;

    // ring mirror and queue of result words still to come
    class t_ring_scoreboard;
        bit               owned [RING_SLOTS];
        int               prod;
        int               cons;
        int               free_cnt;
        logic [LEN_W-1:0] min_len;
        t_result          expected_q [$];
        int               errors;
        int               posts;
        int               rejects;
        int               walks;
        int               completions;
        int               longest_walk;

        function new();
            foreach (owned[i]) owned[i] = 1'b0;
            prod = 0;
            cons = 0;
            free_cnt = RING_SLOTS;
            min_len = MIN_LEN_RESET;
            errors = 0;
            posts = 0;
            rejects = 0;
            walks = 0;
            completions = 0;
            longest_walk = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void add_expected(logic [STATUS_W-1:0] status, int slot, int flen,
                                   int free_left, bit last);
            t_result r;
            r.status       = status;
            r.slot         = SLOT_W'(slot);
            r.padded_len   = LEN_W'(flen);
            r.end_of_ring  = (slot == RING_SLOTS - 1);
            r.free_slots   = FREE_W'(free_left);
            r.last         = last;
            expected_q.push_back(r);
        endfunction

        // called once per accepted input word
        function void note_word(logic [KIND_W-1:0] kind, logic [LEN_W-1:0] plen,
                                logic [SLOT_W-1:0] dslot);
            int n;
            int s;
            case (kind)
                KIND_POST: begin
                    if (free_cnt == 0) begin
                        add_expected(ST_FULL, prod, 0, 0, 1'b1);
                        rejects++;
                    end else begin
                        s = prod;
                        owned[s] = 1'b1;
                        prod = (prod + 1) % RING_SLOTS;
                        free_cnt--;
                        add_expected(ST_POSTED, s, (plen > min_len) ? plen : min_len,
                                     free_cnt, 1'b1);
                        posts++;
                    end
                end
                KIND_DONE: begin
                    if (int'(dslot) < RING_SLOTS) owned[dslot] = 1'b0;
                end
                KIND_WALK: begin
                    n = 0;
                    while (free_cnt < RING_SLOTS && n < int'(WALK_MAX) && !owned[cons]) begin
                        s = cons;
                        cons = (cons + 1) % RING_SLOTS;
                        free_cnt++;
                        add_expected(ST_DONE, s, 0, free_cnt, 1'b0);
                        n++;
                    end
                    add_expected(ST_END, cons, 0, free_cnt, 1'b1);
                    walks++;
                    completions += n;
                    if (n > longest_walk) longest_walk = n;
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        // called once per accepted result word
        function void check_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                                   logic [LEN_W-1:0] flen, logic eor,
                                   logic [FREE_W-1:0] free_left, logic last);
            t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual status %0d slot %0d",
                         $time, status, slot);
                return;
            end
            want = expected_q.pop_front();
            compare_field("status", want.status, status);
            compare_field("slot", want.slot, slot);
            compare_field("padded_len", want.padded_len, flen);
            compare_field("end_of_ring", want.end_of_ring, eor);
            compare_field("free_slots", want.free_slots, free_left);
            compare_field("last", want.last, last);
        endfunction
    endclass

    // clock, reset and block inputs, all known from time zero
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [LEN_W-1:0]    i_cfg_wdata = '0;
    logic                i_in_valid = 1'b0;
    logic [KIND_W-1:0]   i_kind = '0;
    logic [LEN_W-1:0]    i_payload_length = '0;
    logic [SLOT_W-1:0]   i_done_slot = '0;
    logic                i_out_stall = 1'b0;

    logic                o_in_stall;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot;
    logic [LEN_W-1:0]    o_padded_len;
    logic                o_end_of_ring;
    logic [FREE_W-1:0]   o_free_slots;
    logic                o_last;

    t_ring_scoreboard sb = new();

    // idle chances in percent, changed per phase; zero means back to back
    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int out_hold = 0;
    int words_sent = 0;
    int cfg_writes = 0;

    tx_descriptor_ring #(
        .RING_DEPTH(RING_SLOTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_payload_length(i_payload_length),
        .i_done_slot     (i_done_slot),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_padded_len    (o_padded_len),
        .o_end_of_ring   (o_end_of_ring),
        .o_free_slots    (o_free_slots),
        .o_last          (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver side: random stall bursts at the phase's rate
    always @(posedge i_clk) begin
        if (out_hold > 0) begin
            out_hold <= out_hold - 1;
        end else if (out_stall_pct > 0 && $urandom_range(1, 100) <= out_stall_pct) begin
            i_out_stall <= 1'b1;
            out_hold <= $urandom_range(0, 6);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // every result word taken is checked against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_status, o_slot, o_padded_len, o_end_of_ring,
                            o_free_slots, o_last);
        end
    end

    // offer one input word, optionally after an idle burst, and hold it until taken;
    // returns at the edge that accepted it
    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [LEN_W-1:0] plen,
                             input logic [SLOT_W-1:0] dslot);
        if (in_idle_pct > 0 && $urandom_range(1, 100) <= in_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_kind           <= kind;
        i_payload_length <= plen;
        i_done_slot      <= dslot;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(kind, plen, dslot);
        if (kind != KIND_UNUSED) words_sent++;
    endtask

    function automatic logic [LEN_W-1:0] rand_len();
        return LEN_W'($urandom_range(0, 4095));
    endfunction

    function automatic logic [SLOT_W-1:0] rand_slot();
        return SLOT_W'($urandom_range(0, RING_SLOTS - 1));
    endfunction

    // frame lengths: mostly in range, some near the pad threshold, some extremes
    function automatic logic [LEN_W-1:0] pick_length();
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return '0;
            1: return '1;
            2: begin
                v = int'(sb.min_len) + $urandom_range(0, 4) - 2;
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
                return LEN_W'(v);
            end
            3: return rand_len();
            default: return LEN_W'($urandom_range(0, 2048));
        endcase
    endfunction

    // a slot somewhere in the outstanding window, usually one the nic still owns
    function automatic logic [SLOT_W-1:0] pick_owned_slot();
        int offset;
        if (sb.free_cnt >= RING_SLOTS) return rand_slot();
        offset = $urandom_range(0, RING_SLOTS - 1 - sb.free_cnt);
        return SLOT_W'((sb.cons + offset) % RING_SLOTS);
    endfunction

    function automatic int pick_rate();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    // drain the block, let it settle, then write min_frame_len
    task automatic write_min_len(input logic [LEN_W-1:0] value);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (IDLE_GUARD) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.min_len = value;
        cfg_writes++;
    endtask

    // fill the ring to the brim, hit it with rejects, hand every slot back in
    // random order, then two walks: the first stops at the per-walk cap
    task automatic fill_and_drain();
        int order [RING_SLOTS];
        int j;
        int tmp;
        while (sb.free_cnt != 0) send_word(KIND_POST, pick_length(), rand_slot());
        repeat (2) send_word(KIND_POST, pick_length(), rand_slot());
        for (int k = 0; k < RING_SLOTS; k++) order[k] = k;
        for (int k = RING_SLOTS - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < RING_SLOTS; k++) begin
            send_word(KIND_DONE, rand_len(), SLOT_W'(order[k]));
        end
        repeat (2) send_word(KIND_WALK, rand_len(), rand_slot());
    endtask

    // mixed traffic: post bursts, nic done bursts on owned slots, walks, and
    // a little noise (unused kind, done on arbitrary slots)
    task automatic run_mixed_traffic(input int target);
        int start;
        int sel;
        int n;
        start = words_sent;
        while (words_sent - start < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                n = $urandom_range(1, 8);
                repeat (n) send_word(KIND_POST, pick_length(), rand_slot());
            end else if (sel < 70) begin
                n = $urandom_range(1, 6);
                repeat (n) send_word(KIND_DONE, rand_len(), pick_owned_slot());
            end else if (sel < 92) begin
                send_word(KIND_WALK, rand_len(), rand_slot());
            end else if (sel < 96) begin
                send_word(KIND_UNUSED, rand_len(), rand_slot());
            end else begin
                send_word(KIND_DONE, rand_len(), rand_slot());
            end
        end
    endtask

    initial begin : main
        logic [LEN_W-1:0] phase_len [NUM_PHASES];

        // pad settings per phase: zero, range top, all ones, one, two random,
        // a typical frame size and back to the reset value
        phase_len[0] = '0;
        phase_len[1] = 12'd2048;
        phase_len[2] = '1;
        phase_len[3] = 12'd1;
        phase_len[4] = LEN_W'($urandom_range(0, 2048));
        phase_len[5] = LEN_W'($urandom_range(0, 2048));
        phase_len[6] = 12'd1514;
        phase_len[7] = MIN_LEN_RESET;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        in_idle_pct = 20;
        out_stall_pct = 20;

        // directed part at the reset pad length
        send_word(KIND_WALK, 12'd0, 6'd0);       // walk on an empty ring
        send_word(KIND_POST, 12'd0, 6'd0);       // zero length, padded up
        send_word(KIND_POST, 12'd59, 6'd0);
        send_word(KIND_POST, 12'd60, 6'd0);      // exactly at the threshold
        send_word(KIND_POST, 12'd61, 6'd0);
        send_word(KIND_POST, 12'd4095, 6'd63);   // all length bits set
        send_word(KIND_POST, 12'd2048, 6'd0);
        send_word(KIND_DONE, 12'd0, 6'd1);
        send_word(KIND_WALK, 12'd0, 6'd0);       // head still owned, end marker only
        send_word(KIND_DONE, 12'd4095, 6'd0);
        send_word(KIND_WALK, 12'd0, 6'd0);       // releases two, stops at an owned slot
        send_word(KIND_DONE, 12'd0, 6'd63);      // slot not owned, no effect
        send_word(KIND_UNUSED, 12'd4095, 6'd63); // unused kind, ignored
        send_word(KIND_DONE, 12'd0, 6'd5);       // hand back out of order
        send_word(KIND_DONE, 12'd0, 6'd4);
        send_word(KIND_DONE, 12'd0, 6'd3);
        send_word(KIND_DONE, 12'd0, 6'd2);
        send_word(KIND_WALK, 12'd0, 6'd0);       // empties the ring
        send_word(KIND_WALK, 12'd0, 6'd0);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            write_min_len(phase_len[phase]);
            // the last phase runs with no idling on either side
            if (phase == NUM_PHASES - 1) begin
                in_idle_pct = 0;
                out_stall_pct = 0;
            end else begin
                in_idle_pct = pick_rate();
                out_stall_pct = pick_rate();
            end
            if (phase == 1 || phase == 5) fill_and_drain();
            run_mixed_traffic(PHASE_WORDS);
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (IDLE_GUARD * 4) @(posedge i_clk);
        if (sb.pending() != 0) sb.errors++;

        $display("run: %0d words, %0d posts, %0d ring-full rejects, %0d walks releasing %0d slots",
                 words_sent, sb.posts, sb.rejects, sb.walks, sb.completions);
        $display("run: longest walk %0d slots, %0d pad length settings", sb.longest_walk,
                 cfg_writes);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #50_000_000;
        $display("timeout: block stopped making progress");
        $display("DONE: errors detected");
        $finish;
    end

endmodule
